### src/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define RCE_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("ray cylinder assertion failed");

// Condition that must never be seen outside reset.
`define RCE_ASSERT_NEVER(name, clk, rstn, cond) \
  `RCE_ASSERT(name, clk, rstn, !(cond))

`endif

### src/rce_pkg.sv
package rce_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 3;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_BOTTOM_Y     = 3'd0,
    CFG_TOP_Y        = 3'd1,
    CFG_RADIUS       = 3'd2,
    CFG_INV_RADIUS   = 3'd3,
    CFG_MIN_DISTANCE = 3'd4
  } cfg_idx_e;

  // Register reset values.
  localparam logic signed [31:0] BottomRst = -32'sd65536;
  localparam logic signed [31:0] TopRst    = 32'sd65536;
  localparam logic [30:0]        RadiusRst = 31'd65536;
  localparam logic [30:0]        InvRst    = 31'd65536;
  localparam logic [16:0]        MinDstRst = 17'd7;

  // Saturated distance and pipeline step counts.
  localparam logic [30:0] TMax      = '1;
  localparam int unsigned SqrtSteps = 64;
  localparam int unsigned DivSteps  = 31;

  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
  } ray_t;

  typedef struct packed {
    logic signed [31:0] bottom;
    logic signed [31:0] top;
    logic [30:0]        radius;
    logic [30:0]        inv;
    logic [16:0]        mind;
  } cfg_t;

  // Quadratic terms that travel with the ray.
  typedef struct packed {
    ray_t        ray;
    logic [63:0] a;
    logic        hneg;
    logic [63:0] hm;
    logic        miss;
  } core_t;

  typedef struct packed {
    ray_t        ray;
    logic [30:0] t_s;
    logic [30:0] t_l;
    logic        ok_s;
    logic        ok_l;
  } div_t;

  typedef struct packed {
    logic               hit;
    logic [30:0]        distance;
    logic signed [15:0] nx;
    logic signed [15:0] nz;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } hit_t;

endpackage

### src/rce_if.sv
// Ray input channel.
interface rce_ray_if import rce_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [31:0] direction_x;
  logic signed [31:0] direction_y;
  logic signed [31:0] direction_z;

  modport source (output valid, origin_x, origin_y, origin_z,
                  direction_x, direction_y, direction_z, input ready);
  modport sink (input valid, origin_x, origin_y, origin_z,
                direction_x, direction_y, direction_z, output ready);
endinterface

// Intersection result channel.
interface rce_hit_if import rce_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               hit;
  logic [30:0]        hit_distance;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_z;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;

  modport source (output valid, hit, hit_distance, normal_x, normal_z,
                  point_x, point_y, point_z, input ready);
  modport sink (input valid, hit, hit_distance, normal_x, normal_z,
                point_x, point_y, point_z, output ready);
endinterface

// Configuration write channel.
interface rce_cfg_if import rce_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [31:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/ray_open_cylinder_intersect.sv
// Ray against open y-aligned cylinder, one ray per cycle.
// From the ray transfer, each ray passes 5 setup, 64 square-root, 33 divide and 7 hit-test
// stages and then the output buffer before its result can transfer.
// Throughput: one ray per cycle; the pipeline holds while the two-entry output buffer is full.
// Reset clears all valid bits and the output buffer and loads the register defaults.
`include "assert_macros.svh"

module ray_open_cylinder_intersect import rce_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  rce_cfg_if.sink   cfg_i,
  rce_ray_if.sink   ray_i,
  rce_hit_if.source hit_o
);

  logic signed [31:0] bottom_q, top_q;
  logic [30:0]        radius_q, inv_q;
  logic [16:0]        mind_q;
  cfg_t               cfg;

  logic        en;
  ray_t        in_ray;
  logic        fv, sv, dv, hv;
  core_t       fcore, score;
  logic [127:0] disc;
  logic [63:0] root;
  div_t        dres;
  hit_t        hres;

  hit_t        buf_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        push, pop;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bottom_q <= BottomRst;
      top_q    <= TopRst;
      radius_q <= RadiusRst;
      inv_q    <= InvRst;
      mind_q   <= MinDstRst;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_BOTTOM_Y:     bottom_q <= cfg_i.data;
        CFG_TOP_Y:        top_q    <= cfg_i.data;
        CFG_RADIUS:       radius_q <= cfg_i.data[30:0];
        CFG_INV_RADIUS:   inv_q    <= cfg_i.data[30:0];
        CFG_MIN_DISTANCE: mind_q   <= cfg_i.data[16:0];
        default: ;
      endcase
    end
  end

  assign cfg.bottom = bottom_q;
  assign cfg.top    = top_q;
  assign cfg.radius = radius_q;
  assign cfg.inv    = inv_q;
  assign cfg.mind   = mind_q;

  // The whole pipeline advances while the output buffer has room.
  assign en          = (cnt_q != 2'd2);
  assign ray_i.ready = en;

  assign in_ray.ox = ray_i.origin_x;
  assign in_ray.oy = ray_i.origin_y;
  assign in_ray.oz = ray_i.origin_z;
  assign in_ray.dx = ray_i.direction_x;
  assign in_ray.dy = ray_i.direction_y;
  assign in_ray.dz = ray_i.direction_z;

  rce_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ray_i.valid),
    .ray_i   (in_ray),
    .cfg_i   (cfg),
    .valid_o (fv),
    .core_o  (fcore),
    .disc_o  (disc)
  );

  rce_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fv),
    .core_i  (fcore),
    .disc_i  (disc),
    .valid_o (sv),
    .core_o  (score),
    .root_o  (root)
  );

  rce_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sv),
    .core_i  (score),
    .root_i  (root),
    .valid_o (dv),
    .div_o   (dres)
  );

  rce_hit u_hit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv),
    .div_i   (dres),
    .cfg_i   (cfg),
    .valid_o (hv),
    .hit_o   (hres)
  );

  // Two-entry output buffer decouples the pipeline from the result consumer.
  assign push = hv && en;
  assign pop  = hit_o.valid && hit_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= hres;
    end
  end

  assign hit_o.valid        = (cnt_q != 2'd0);
  assign hit_o.hit          = buf_q[rd_q].hit;
  assign hit_o.hit_distance = buf_q[rd_q].distance;
  assign hit_o.normal_x     = buf_q[rd_q].nx;
  assign hit_o.normal_z     = buf_q[rd_q].nz;
  assign hit_o.point_x      = buf_q[rd_q].px;
  assign hit_o.point_y      = buf_q[rd_q].py;
  assign hit_o.point_z      = buf_q[rd_q].pz;

  // Buffer occupancy never passes two entries.
  `RCE_ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q == 2'd3)
  // A miss carries all-zero fields.
  `RCE_ASSERT(a_miss_zero, clk_i, rst_ni,
    hit_o.valid && !hit_o.hit |-> hit_o.hit_distance == 31'd0 &&
    hit_o.point_x == 32'sd0 && hit_o.normal_x == 16'sd0)
  // A reported normal stays within one unit.
  `RCE_ASSERT(a_norm_range, clk_i, rst_ni,
    hit_o.valid && hit_o.hit |-> hit_o.normal_x <= 16'sd16384 &&
    hit_o.normal_x >= -16'sd16384 && hit_o.normal_z <= 16'sd16384 &&
    hit_o.normal_z >= -16'sd16384)
  // A hit lies beyond the minimum distance.
  `RCE_ASSERT(a_hit_dist, clk_i, rst_ni,
    hit_o.valid && hit_o.hit |-> hit_o.hit_distance > {14'd0, mind_q})

endmodule

### src/rce_front.sv
module rce_front import rce_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  ray_t          ray_i,
  input  cfg_t          cfg_i,
  output logic          valid_o,
  output core_t         core_o,
  output logic [127:0]  disc_o
);

  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  ray_t               ray1_q;
  logic signed [63:0] dxx1_q, dzz1_q, oxdx1_q, ozdz1_q, oxx1_q, ozz1_q;
  logic [61:0]        r2_1_q;

  core_t       c2_d, c2_q, c3_q, c4_q, c5_d, c5_q;
  logic        cneg2_d, cneg2_q, cneg3_q, cneg4_q;
  logic [63:0] cm2_d, cm2_q;
  logic [64:0] h2s, hneg_v;
  logic [63:0] s2;

  logic [63:0]  hll3_q, hlh3_q, hhh3_q, all3_q, alh3_q, ahl3_q, ahh3_q;
  logic [127:0] h2_d, ac_d, h2_q, ac_q, disc_d, disc_q;
  logic         miss5_d;

  // Valid bits follow the data through every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Stage 1: all first-level products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ray1_q  <= ray_i;
      dxx1_q  <= ray_i.dx * ray_i.dx;
      dzz1_q  <= ray_i.dz * ray_i.dz;
      oxdx1_q <= ray_i.ox * ray_i.dx;
      ozdz1_q <= ray_i.oz * ray_i.dz;
      oxx1_q  <= ray_i.ox * ray_i.ox;
      ozz1_q  <= ray_i.oz * ray_i.oz;
      r2_1_q  <= cfg_i.radius * cfg_i.radius;
    end
  end

  // Stage 2: a, the magnitude and sign of h, and the magnitude and sign of c.
  always_comb begin
    h2s     = {oxdx1_q[63], oxdx1_q} + {ozdz1_q[63], ozdz1_q};
    hneg_v  = 65'd0 - h2s;
    s2      = $unsigned(oxx1_q) + $unsigned(ozz1_q);
    cneg2_d = s2 < {2'b00, r2_1_q};
    cm2_d   = cneg2_d ? ({2'b00, r2_1_q} - s2) : (s2 - {2'b00, r2_1_q});
    c2_d.ray  = ray1_q;
    c2_d.a    = $unsigned(dxx1_q) + $unsigned(dzz1_q);
    c2_d.hneg = h2s[64];
    c2_d.hm   = h2s[64] ? hneg_v[63:0] : h2s[63:0];
    c2_d.miss = 1'b0;
    c2_d.miss = (c2_d.a == 64'd0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c2_q    <= c2_d;
      cneg2_q <= cneg2_d;
      cm2_q   <= cm2_d;
    end
  end

  // Stage 3: 32 by 32 partial products of h*h and a*c.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c3_q    <= c2_q;
      cneg3_q <= cneg2_q;
      hll3_q  <= c2_q.hm[31:0] * c2_q.hm[31:0];
      hlh3_q  <= c2_q.hm[31:0] * c2_q.hm[63:32];
      hhh3_q  <= c2_q.hm[63:32] * c2_q.hm[63:32];
      all3_q  <= c2_q.a[31:0] * cm2_q[31:0];
      alh3_q  <= c2_q.a[31:0] * cm2_q[63:32];
      ahl3_q  <= c2_q.a[63:32] * cm2_q[31:0];
      ahh3_q  <= c2_q.a[63:32] * cm2_q[63:32];
    end
  end

  // Stage 4: sum the partial products into full 128-bit terms.
  always_comb begin
    h2_d = {hhh3_q, hll3_q} + ({64'd0, hlh3_q} << 33);
    ac_d = {ahh3_q, all3_q} + ({64'd0, alh3_q} << 32) + ({64'd0, ahl3_q} << 32);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c4_q    <= c3_q;
      cneg4_q <= cneg3_q;
      h2_q    <= h2_d;
      ac_q    <= ac_d;
    end
  end

  // Stage 5: discriminant h^2 - a*c; a negative one is a miss.
  always_comb begin
    if (cneg4_q) begin
      disc_d  = h2_q + ac_q;
      miss5_d = c4_q.miss;
    end else begin
      disc_d  = h2_q - ac_q;
      miss5_d = c4_q.miss || (h2_q < ac_q);
    end
    c5_d      = c4_q;
    c5_d.miss = miss5_d;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c5_q   <= c5_d;
      disc_q <= disc_d;
    end
  end

  assign valid_o = v5_q;
  assign core_o  = c5_q;
  assign disc_o  = disc_q;

endmodule

### src/rce_sqrt.sv
module rce_sqrt import rce_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  core_t        core_i,
  input  logic [127:0] disc_i,
  output logic         valid_o,
  output core_t        core_o,
  output logic [63:0]  root_o
);

  logic         v_q    [SqrtSteps];
  core_t        core_q [SqrtSteps];
  logic [65:0]  rem_q  [SqrtSteps];
  logic [63:0]  root_q [SqrtSteps];
  logic [127:0] dsh_q  [SqrtSteps];

  // One result bit per stage, two radicand bits consumed per stage.
  for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
    logic         v_in;
    core_t        c_in;
    logic [65:0]  rem_in;
    logic [63:0]  root_in;
    logic [127:0] d_in;
    logic [67:0]  acc;
    logic [67:0]  trial;
    logic         ge;

    if (k == 0) begin : g_head
      assign v_in    = valid_i;
      assign c_in    = core_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign d_in    = disc_i;
    end else begin : g_tail
      assign v_in    = v_q[k-1];
      assign c_in    = core_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign d_in    = dsh_q[k-1];
    end

    assign acc   = {rem_in, d_in[127:126]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = acc >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        core_q[k] <= c_in;
        dsh_q[k]  <= d_in << 2;
        rem_q[k]  <= ge ? 66'(acc - trial) : acc[65:0];
        root_q[k] <= {root_in[62:0], ge};
      end
    end
  end

  assign valid_o = v_q[SqrtSteps-1];
  assign core_o  = core_q[SqrtSteps-1];
  assign root_o  = root_q[SqrtSteps-1];

endmodule

### src/rce_div.sv
module rce_div import rce_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  core_t       core_i,
  input  logic [63:0] root_i,
  output logic        valid_o,
  output div_t        div_o
);

  // Lane 0 is the near root, lane 1 the far root.
  logic        va_q, vb_q;
  core_t       ca_q, cb_q;
  logic [64:0] num_d [2];
  logic        ok_d  [2];
  logic [64:0] num_q [2];
  logic        oka_q [2];

  logic [63:0] rem0_q [2];
  logic [30:0] x0_q   [2];
  logic        ovf0_q [2];
  logic        ok0_q  [2];

  logic        v_q    [DivSteps];
  core_t       core_q [DivSteps];
  logic [63:0] rem_q  [DivSteps][2];
  logic [30:0] x_q    [DivSteps][2];
  logic [30:0] quo_q  [DivSteps][2];
  logic        ovf_q  [DivSteps][2];
  logic        ok_q   [DivSteps][2];

  // Stage A: numerators of both roots and whether each is usable.
  always_comb begin
    num_d[0] = {1'b0, core_i.hm - root_i};
    ok_d[0]  = !core_i.miss && core_i.hneg && (core_i.hm > root_i);
    if (core_i.hneg) begin
      num_d[1] = {1'b0, core_i.hm} + {1'b0, root_i};
      ok_d[1]  = !core_i.miss && ((core_i.hm != 64'd0) || (root_i != 64'd0));
    end else begin
      num_d[1] = {1'b0, root_i - core_i.hm};
      ok_d[1]  = !core_i.miss && (root_i > core_i.hm);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ca_q <= core_i;
      for (int l = 0; l < 2; l++) begin
        num_q[l] <= num_d[l];
        oka_q[l] <= ok_d[l];
      end
    end
  end

  // Stage B: a quotient of 2^31 or more saturates; the rest seeds the divider.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cb_q <= ca_q;
      for (int l = 0; l < 2; l++) begin
        ovf0_q[l] <= {14'd0, num_q[l]} >= {ca_q.a, 15'd0};
        rem0_q[l] <= {14'd0, num_q[l][64:15]};
        x0_q[l]   <= {num_q[l][14:0], 16'd0};
        ok0_q[l]  <= oka_q[l];
      end
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic        v_in;
    core_t       c_in;
    logic [63:0] rem_in [2];
    logic [30:0] x_in   [2];
    logic [30:0] quo_in [2];
    logic        ovf_in [2];
    logic        ok_in  [2];
    logic [64:0] acc    [2];
    logic        ge     [2];

    if (k == 0) begin : g_head
      assign v_in   = vb_q;
      assign c_in   = cb_q;
      assign rem_in = rem0_q;
      assign x_in   = x0_q;
      assign quo_in = '{default: '0};
      assign ovf_in = ovf0_q;
      assign ok_in  = ok0_q;
    end else begin : g_tail
      assign v_in   = v_q[k-1];
      assign c_in   = core_q[k-1];
      assign rem_in = rem_q[k-1];
      assign x_in   = x_q[k-1];
      assign quo_in = quo_q[k-1];
      assign ovf_in = ovf_q[k-1];
      assign ok_in  = ok_q[k-1];
    end

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        acc[l] = {rem_in[l], x_in[l][30]};
        ge[l]  = acc[l] >= {1'b0, c_in.a};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        core_q[k] <= c_in;
        for (int l = 0; l < 2; l++) begin
          rem_q[k][l] <= ge[l] ? 64'(acc[l] - {1'b0, c_in.a}) : acc[l][63:0];
          x_q[k][l]   <= {x_in[l][29:0], 1'b0};
          quo_q[k][l] <= {quo_in[l][29:0], ge[l]};
          ovf_q[k][l] <= ovf_in[l];
          ok_q[k][l]  <= ok_in[l];
        end
      end
    end
  end

  assign valid_o    = v_q[DivSteps-1];
  assign div_o.ray  = core_q[DivSteps-1].ray;
  assign div_o.t_s  = ovf_q[DivSteps-1][0] ? TMax : quo_q[DivSteps-1][0];
  assign div_o.t_l  = ovf_q[DivSteps-1][1] ? TMax : quo_q[DivSteps-1][1];
  assign div_o.ok_s = ok_q[DivSteps-1][0];
  assign div_o.ok_l = ok_q[DivSteps-1][1];

endmodule

### src/rce_hit.sv
module rce_hit import rce_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  div_t div_i,
  input  cfg_t cfg_i,
  output logic valid_o,
  output hit_t hit_o
);

  // Clamp to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Clamp a normal component to plus or minus one in Q2.14.
  function automatic logic signed [15:0] satn(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd16384) begin
      r = 16'sd16384;
    end else if (v < -64'sd16384) begin
      r = -16'sd16384;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  logic v_q [7];
  ray_t ray1_q, ray2_q, ray3_q, ray4_q, ray5_q;

  logic [30:0]        t_in [2];
  logic               ok_in [2];
  logic signed [31:0] ts [2];

  logic               ok1_q [2];
  logic [30:0]        t1_q  [2];
  logic signed [63:0] mx1_q [2], my1_q [2], mz1_q [2];

  logic signed [63:0] bot_l, top_l, oxs, oys, ozs;
  logic signed [63:0] y2 [2], px2f [2], pz2f [2];
  logic               ok2_q [2];
  logic [30:0]        t2_q  [2];
  logic signed [31:0] px2_q [2], py2_q [2], pz2_q [2];

  logic signed [31:0] inv_s;
  logic               ok3_q [2];
  logic [30:0]        t3_q  [2];
  logic signed [31:0] px3_q [2], py3_q [2], pz3_q [2];
  logic signed [63:0] nxp3_q [2], nzp3_q [2];

  logic               ok4_q [2];
  logic [30:0]        t4_q  [2];
  logic signed [31:0] px4_q [2], py4_q [2], pz4_q [2];
  logic signed [15:0] nx4_q [2], nz4_q [2];

  logic               ok5_q [2];
  logic [30:0]        t5_q  [2];
  logic signed [31:0] px5_q [2], py5_q [2], pz5_q [2];
  logic signed [15:0] nx5_q [2], nz5_q [2];
  logic signed [47:0] pdx5_q [2], pdz5_q [2];

  logic signed [48:0] dot6 [2];
  hit_t               lane6_d [2];
  hit_t               lane6_q [2];
  hit_t               out_d, out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < 7; s++) begin
        v_q[s] <= 1'b0;
      end
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int s = 1; s < 7; s++) begin
        v_q[s] <= v_q[s-1];
      end
    end
  end

  // Stage 1: distance test and t times each direction component.
  always_comb begin
    t_in[0]  = div_i.t_s;
    t_in[1]  = div_i.t_l;
    ok_in[0] = div_i.ok_s;
    ok_in[1] = div_i.ok_l;
    for (int l = 0; l < 2; l++) begin
      ts[l] = {1'b0, t_in[l]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ray1_q <= div_i.ray;
      for (int l = 0; l < 2; l++) begin
        ok1_q[l] <= ok_in[l] && (t_in[l] > {14'd0, cfg_i.mind});
        t1_q[l]  <= t_in[l];
        mx1_q[l] <= ts[l] * div_i.ray.dx;
        my1_q[l] <= ts[l] * div_i.ray.dy;
        mz1_q[l] <= ts[l] * div_i.ray.dz;
      end
    end
  end

  // Stage 2: hit point in Q32.32, height test, point back to Q16.16.
  always_comb begin
    bot_l = {{16{cfg_i.bottom[31]}}, cfg_i.bottom, 16'd0};
    top_l = {{16{cfg_i.top[31]}}, cfg_i.top, 16'd0};
    oxs   = {{16{ray1_q.ox[31]}}, ray1_q.ox, 16'd0};
    oys   = {{16{ray1_q.oy[31]}}, ray1_q.oy, 16'd0};
    ozs   = {{16{ray1_q.oz[31]}}, ray1_q.oz, 16'd0};
    for (int l = 0; l < 2; l++) begin
      y2[l]   = oys + my1_q[l];
      px2f[l] = oxs + mx1_q[l];
      pz2f[l] = ozs + mz1_q[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ray2_q <= ray1_q;
      for (int l = 0; l < 2; l++) begin
        ok2_q[l] <= ok1_q[l] && (y2[l] > bot_l) && (y2[l] < top_l);
        t2_q[l]  <= t1_q[l];
        px2_q[l] <= sat32(px2f[l] >>> 16);
        py2_q[l] <= sat32(y2[l] >>> 16);
        pz2_q[l] <= sat32(pz2f[l] >>> 16);
      end
    end
  end

  // Stage 3: point times the inverse radius.
  assign inv_s = {1'b0, cfg_i.inv};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ray3_q <= ray2_q;
      for (int l = 0; l < 2; l++) begin
        ok3_q[l]  <= ok2_q[l];
        t3_q[l]   <= t2_q[l];
        px3_q[l]  <= px2_q[l];
        py3_q[l]  <= py2_q[l];
        pz3_q[l]  <= pz2_q[l];
        nxp3_q[l] <= px2_q[l] * inv_s;
        nzp3_q[l] <= pz2_q[l] * inv_s;
      end
    end
  end

  // Stage 4: scale the normal to Q2.14 and clamp it.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ray4_q <= ray3_q;
      for (int l = 0; l < 2; l++) begin
        ok4_q[l] <= ok3_q[l];
        t4_q[l]  <= t3_q[l];
        px4_q[l] <= px3_q[l];
        py4_q[l] <= py3_q[l];
        pz4_q[l] <= pz3_q[l];
        nx4_q[l] <= satn(nxp3_q[l] >>> 18);
        nz4_q[l] <= satn(nzp3_q[l] >>> 18);
      end
    end
  end

  // Stage 5: direction against normal products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ray5_q <= ray4_q;
      for (int l = 0; l < 2; l++) begin
        ok5_q[l]  <= ok4_q[l];
        t5_q[l]   <= t4_q[l];
        px5_q[l]  <= px4_q[l];
        py5_q[l]  <= py4_q[l];
        pz5_q[l]  <= pz4_q[l];
        nx5_q[l]  <= nx4_q[l];
        nz5_q[l]  <= nz4_q[l];
        pdx5_q[l] <= ray4_q.dx * nx4_q[l];
        pdz5_q[l] <= ray4_q.dz * nz4_q[l];
      end
    end
  end

  // Stage 6: turn the normal toward the ray when it points away.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      dot6[l]             = {pdx5_q[l][47], pdx5_q[l]} + {pdz5_q[l][47], pdz5_q[l]};
      lane6_d[l].hit      = ok5_q[l];
      lane6_d[l].distance = t5_q[l];
      lane6_d[l].px       = px5_q[l];
      lane6_d[l].py       = py5_q[l];
      lane6_d[l].pz       = pz5_q[l];
      if (dot6[l] > 49'sd0) begin
        lane6_d[l].nx = -nx5_q[l];
        lane6_d[l].nz = -nz5_q[l];
      end else begin
        lane6_d[l].nx = nx5_q[l];
        lane6_d[l].nz = nz5_q[l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 2; l++) begin
        lane6_q[l] <= lane6_d[l];
      end
    end
  end

  // Stage 7: the near root wins; a miss reports all zeros.
  always_comb begin
    if (lane6_q[0].hit) begin
      out_d = lane6_q[0];
    end else if (lane6_q[1].hit) begin
      out_d = lane6_q[1];
    end else begin
      out_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign valid_o = v_q[6];
  assign hit_o   = out_q;

endmodule

### bench/tb_top.sv
module tb_top;
  import rce_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint One        = 65536;
  localparam int     CycleLimit = 400000;
  localparam int     DrainWait  = 150;

  logic clk_i;
  logic rst_ni;

  rce_ray_if ray_if ();
  rce_hit_if hit_if ();
  rce_cfg_if cfg_if ();

  ray_open_cylinder_intersect i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .ray_i  (ray_if),
    .hit_o  (hit_if)
  );

  // Register copies used by the intersection predictor.
  logic signed [31:0] cyl_bottom;
  logic signed [31:0] cyl_top;
  logic [30:0]        cyl_radius;
  logic [30:0]        cyl_inv;
  logic [16:0]        cyl_mind;

  ray_t   ray_q[$];
  hit_t   hit_exp_q[$];
  ray_t   cur_ray;
  bit     ray_taken;
  int     send_idle_pct;
  int     recv_idle_pct;
  bit     stall_req;
  int     stall_left;
  int     mismatches;
  int     cycles;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Checks one candidate root; fills the hit record when it is accepted.
  function automatic bit root_accept(logic signed [135:0] num, logic [63:0] a, ray_t r,
                                     output hit_t res);
    logic [135:0] q;
    logic [30:0]  t;
    longint       ti, y, px, py, pz, nx, nz;
    res = '0;
    q = ({num} << 16) / {72'b0, a};
    t = (q >= 136'h8000_0000) ? TMax : q[30:0];
    if ({14'b0, t} <= {14'b0, cyl_mind}) return 1'b0;
    ti = longint'(t);
    y = longint'(r.oy) * One + ti * longint'(r.dy);
    if (!(y > longint'(cyl_bottom) * One && y < longint'(cyl_top) * One)) return 1'b0;
    px = sat((longint'(r.ox) * One + ti * longint'(r.dx)) >>> 16, -(64'sd1 <<< 31),
             (64'sd1 <<< 31) - 1);
    py = sat(y >>> 16, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
    pz = sat((longint'(r.oz) * One + ti * longint'(r.dz)) >>> 16, -(64'sd1 <<< 31),
             (64'sd1 <<< 31) - 1);
    nx = sat((px * longint'({33'b0, cyl_inv})) >>> 18, -16384, 16384);
    nz = sat((pz * longint'({33'b0, cyl_inv})) >>> 18, -16384, 16384);
    // Turn the normal so that it faces the incoming ray.
    if (longint'(r.dx) * nx + longint'(r.dz) * nz > 0) begin
      nx = -nx;
      nz = -nz;
    end
    res.hit      = 1'b1;
    res.distance = t;
    res.nx       = nx[15:0];
    res.nz       = nz[15:0];
    res.px       = px[31:0];
    res.py       = py[31:0];
    res.pz       = pz[31:0];
    return 1'b1;
  endfunction

  // Expected intersection of one ray with the configured cylinder wall.
  function automatic hit_t cyl_intersect(ray_t r);
    longint             ox, oz, dx, dz, p1, p2;
    logic [63:0]        a, e, cand;
    logic signed [66:0] h, s, rs, c;
    logic signed [135:0] aw, disc, num;
    logic [135:0]       du, cw;
    hit_t               res;
    hit_t               tmp;
    res = '0;
    ox = r.ox;
    oz = r.oz;
    dx = r.dx;
    dz = r.dz;
    a = 64'(dx * dx) + 64'(dz * dz);
    // A ray parallel to the axis never meets the wall.
    if (a == 0) return res;
    p1 = ox * dx;
    p2 = oz * dz;
    h = p1;
    h = h + p2;
    s = ox;
    s = s * s;
    c = oz;
    s = s + c * c;
    rs = {36'b0, cyl_radius};
    c = s - rs * rs;
    aw = {72'b0, a};
    disc = h * h - aw * c;
    if (disc < 0) return res;
    du = disc;
    e = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = e | (64'd1 << i);
      cw = {72'b0, cand};
      if (cw * cw <= du) e = cand;
    end
    // Near root first, then the far root.
    num = -h - $signed({72'b0, e});
    if (num > 0 && root_accept(num, a, r, tmp)) return tmp;
    num = -h + $signed({72'b0, e});
    if (num > 0 && root_accept(num, a, r, tmp)) return tmp;
    return res;
  endfunction

  function automatic longint srand(longint span);
    return longint'($urandom_range(0, int'(2 * span))) - span;
  endfunction

  // Mostly rays aimed near the axis from around the cylinder, some pure noise.
  function automatic ray_t make_ray();
    ray_t   r;
    int     kind, sh;
    longint rad, span, ox, oz, tx, tz;
    rad = longint'(cyl_radius) + 1;
    span = (rad * 4 > (64'd1 << 30)) ? (64'd1 << 30) : rad * 4;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return r;
    end
    sh = $urandom_range(0, 4);
    ox = srand(span);
    oz = srand(span);
    tx = srand(rad / 2 + 1);
    tz = srand(rad / 2 + 1);
    r.ox = ox[31:0];
    r.oz = oz[31:0];
    r.oy = 32'(srand(2 * One));
    r.dx = 32'(((tx - ox) >>> sh) + srand(3));
    r.dz = 32'(((tz - oz) >>> sh) + srand(3));
    r.dy = 32'(srand(One) >>> sh);
    if (kind == 2) begin
      r.dx = -r.dx;
      r.dz = -r.dz;
    end
    return r;
  endfunction

  function automatic ray_t ray_of(longint ox, longint oy, longint oz,
                                  longint dx, longint dy, longint dz);
    ray_t r;
    r.ox = ox[31:0];
    r.oy = oy[31:0];
    r.oz = oz[31:0];
    r.dx = dx[31:0];
    r.dy = dy[31:0];
    r.dz = dz[31:0];
    return r;
  endfunction

  // Edge cases: extremes, axis-parallel, tangent, inside, above the top, far root.
  task automatic queue_directed();
    ray_q.push_back(ray_of(0, 0, 0, 0, 0, 0));
    ray_q.push_back(ray_of(0, 0, 0, 0, One, 0));
    ray_q.push_back(ray_of(-3 * One, 0, 0, One, 0, 0));
    ray_q.push_back(ray_of(3 * One, 0, One / 4, -One, One / 8, 0));
    ray_q.push_back(ray_of(0, 0, 0, One, 0, One));
    ray_q.push_back(ray_of(-2 * One, 0, One, One, 0, 0));
    ray_q.push_back(ray_of(-3 * One, 0, 0, One, 4 * One, 0));
    ray_q.push_back(ray_of(-3 * One, 0, 0, -One, 0, 0));
    ray_q.push_back(ray_of(-30000 * One, 0, 0, 1, 0, 0));
    ray_q.push_back(ray_of(0, 0, -3 * One, 0, 0, 1));
    ray_q.push_back(ray_of(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                           32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    ray_q.push_back(ray_of(-(64'sd1 <<< 31), -(64'sd1 <<< 31), -(64'sd1 <<< 31),
                           -(64'sd1 <<< 31), -(64'sd1 <<< 31), -(64'sd1 <<< 31)));
    ray_q.push_back(ray_of(-(64'sd1 <<< 31), 0, 32'h7fff_ffff, 32'h7fff_ffff, 0,
                           -(64'sd1 <<< 31)));
    ray_q.push_back(ray_of(One / 2, 0, -One / 2, 1, -1, 1));
    ray_q.push_back(ray_of(0, 2 * One, 0, One, -One, 0));
  endtask

  // One register transfer on the configuration channel.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_BOTTOM_Y:     cyl_bottom = value;
      CFG_TOP_Y:        cyl_top    = value;
      CFG_RADIUS:       cyl_radius = value[30:0];
      CFG_INV_RADIUS:   cyl_inv    = value[30:0];
      CFG_MIN_DISTANCE: cyl_mind   = value[16:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_cylinder(logic [31:0] bot, logic [31:0] top, logic [31:0] rad,
                              logic [31:0] inv, logic [31:0] mind);
    write_reg(CFG_BOTTOM_Y, bot);
    write_reg(CFG_TOP_Y, top);
    write_reg(CFG_RADIUS, rad);
    write_reg(CFG_INV_RADIUS, inv);
    write_reg(CFG_MIN_DISTANCE, mind);
  endtask

  // Feed a batch of rays and wait until every result has come back.
  task automatic run_batch(int n_rand);
    queue_directed();
    for (int i = 0; i < n_rand; i++) ray_q.push_back(make_ray());
    do @(posedge clk_i); while (ray_q.size() != 0 || ray_if.valid || hit_exp_q.size() != 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Main sequence.
  initial begin
    rst_ni = 1'b0;
    ray_if.valid = 1'b0;
    ray_if.origin_x = '0;
    ray_if.origin_y = '0;
    ray_if.origin_z = '0;
    ray_if.direction_x = '0;
    ray_if.direction_y = '0;
    ray_if.direction_z = '0;
    hit_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    cyl_bottom = BottomRst;
    cyl_top = TopRst;
    cyl_radius = RadiusRst;
    cyl_inv = InvRst;
    cyl_mind = MinDstRst;
    send_idle_pct = 38;
    recv_idle_pct = 84;
    stall_req = 1'b0;
    mismatches = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset values first, with one long receiver stall.
    repeat (5) @(posedge clk_i);
    stall_req = 1'b1;
    run_batch(80);

    send_idle_pct = 84;
    recv_idle_pct = 38;
    set_cylinder(-4 * One, 4 * One, 2 * One, One / 2, 0);
    run_batch(80);

    // Extreme settings, plus a write to an unused index.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_cylinder(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1, 65536);
    write_reg(3'd6, 32'hffff_ffff);
    run_batch(80);

    send_idle_pct = 38;
    recv_idle_pct = 84;
    set_cylinder(0, One, 1, 32'h7fff_ffff, 7);
    run_batch(70);

    send_idle_pct = 84;
    recv_idle_pct = 38;
    set_cylinder(32'h8000_0000, 0, 0, 0, 1);
    run_batch(60);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_cylinder(-One, 8 * One, 3 * One, 21845, 100);
    run_batch(90);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Ray driver: offers the next pending ray at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni && (!ray_if.valid || ray_taken)) begin
      ray_taken = 1'b0;
      if (ray_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cur_ray = ray_q.pop_front();
        ray_if.valid       <= 1'b1;
        ray_if.origin_x    <= cur_ray.ox;
        ray_if.origin_y    <= cur_ray.oy;
        ray_if.origin_z    <= cur_ray.oz;
        ray_if.direction_x <= cur_ray.dx;
        ray_if.direction_y <= cur_ray.dy;
        ray_if.direction_z <= cur_ray.dz;
      end else begin
        ray_if.valid <= 1'b0;
      end
    end
  end

  // Record the expected hit when a ray transfer happens.
  always @(posedge clk_i) begin
    if (rst_ni && ray_if.valid && ray_if.ready) begin
      hit_exp_q.push_back(cyl_intersect(cur_ray));
      ray_taken = 1'b1;
    end
  end

  // Result receiver: random back-pressure and one long hold-off.
  always @(negedge clk_i) begin
    if (stall_req) begin
      stall_left = 600;
      stall_req = 1'b0;
    end
    if (!rst_ni) begin
      hit_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      hit_if.ready <= 1'b0;
    end else begin
      hit_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Compare each result transfer with the oldest expected hit.
  always @(posedge clk_i) begin
    hit_t exp_hit;
    hit_t got_hit;
    if (rst_ni && hit_if.valid && hit_if.ready) begin
      got_hit = '{hit_if.hit, hit_if.hit_distance, hit_if.normal_x, hit_if.normal_z,
                  hit_if.point_x, hit_if.point_y, hit_if.point_z};
      if (hit_exp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %p", got_hit);
      end else begin
        exp_hit = hit_exp_q.pop_front();
        if (got_hit !== exp_hit) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", exp_hit, got_hit);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule

### filelist.f
+incdir+src
src/rce_pkg.sv
src/rce_if.sv
src/rce_front.sv
src/rce_sqrt.sv
src/rce_div.sv
src/rce_hit.sv
src/ray_open_cylinder_intersect.sv
bench/tb_top.sv
